FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the top-level design file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: design/srdp_pkg.sv
// ----------------------------------------------------------------------------
// srdp_pkg
// Shared constants, codes and helpers of the scale reading decimal parser
// ----------------------------------------------------------------------------
package srdp_pkg;

  // mantissa width and fraction digit limit
  localparam int MANTISSA_BITS       = 48;
  localparam int MAX_FRACTION_DIGITS = 15;
  localparam int MAG_BITS            = MANTISSA_BITS - 1;

  // ascii codes
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // parser phase
  typedef enum logic [1:0] {
    PH_SEEK = 2'd0,
    PH_INT  = 2'd1,
    PH_FRAC = 2'd2
  } phase_t;

  // result status
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SIGN   = 3'd1,
    ST_NO_POINT  = 3'd2,
    ST_NON_DIGIT = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  // item held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } in_item_t;

  // decoded character
  typedef struct packed {
    logic       is_cr;
    logic       is_plus;
    logic       is_minus;
    logic       is_point;
    logic       is_digit;
    logic [3:0] digit;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] ch);
    char_class_t cc;
    logic [7:0]  diff;
    diff        = ch - CH_ZERO;
    cc.is_cr    = (ch == CH_CR);
    cc.is_plus  = (ch == CH_PLUS);
    cc.is_minus = (ch == CH_MINUS);
    cc.is_point = (ch == CH_POINT);
    cc.is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    cc.digit    = diff[3:0];
    return cc;
  endfunction

endpackage

FILE: design/srdp_in_stage.sv
// ----------------------------------------------------------------------------
// srdp_in_stage
// Input register for received characters
// ----------------------------------------------------------------------------
module srdp_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] char_in
  input  logic               adv,
  output srdp_pkg::in_item_t item
);

  logic       in_valid;
  logic [7:0] in_char;

  // free when empty or when the held character moves on this cycle
  assign s_tready = !in_valid || adv;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  // character payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
    end
  end

  assign item.valid = in_valid;
  assign item.ch    = in_char;

endmodule

FILE: design/srdp_acc.sv
// ----------------------------------------------------------------------------
// srdp_acc
// Saturating decimal multiply-add of one digit into the magnitude
// ----------------------------------------------------------------------------
module srdp_acc (
  input  logic [srdp_pkg::MAG_BITS-1:0] acc,
  input  logic [3:0]                    digit,
  output logic [srdp_pkg::MAG_BITS-1:0] acc_next,
  output logic                          ovf
);

  localparam int WIDE_BITS = srdp_pkg::MAG_BITS + 4;

  logic [WIDE_BITS-1:0] wide;
  logic [WIDE_BITS-1:0] limit;

  // acc * 10 + digit as acc * 8 + acc * 2 + digit
  assign wide  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
               + {{(WIDE_BITS-4){1'b0}}, digit};
  assign limit = {4'b0000, {srdp_pkg::MAG_BITS{1'b1}}};

  // saturate at the largest magnitude
  assign ovf      = (wide > limit);
  assign acc_next = ovf ? {srdp_pkg::MAG_BITS{1'b1}} : wide[srdp_pkg::MAG_BITS-1:0];

endmodule

FILE: design/srdp_parser.sv
// ----------------------------------------------------------------------------
// srdp_parser
// Parse state and result register
// ----------------------------------------------------------------------------
module srdp_parser (
  input  logic                                 clk,
  input  logic                                 rst,
  input  srdp_pkg::in_item_t                   item,
  output logic                                 adv,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [srdp_pkg::MANTISSA_BITS-1:0]   mantissa,
  output logic [3:0]                           frac_digits,
  output logic [2:0]                           status
);

  srdp_pkg::char_class_t cc;

  srdp_pkg::phase_t                  phase, phase_next;
  logic                              negative, negative_next;
  logic [srdp_pkg::MAG_BITS-1:0]     acc, acc_next;
  logic [3:0]                        digit_count, digit_count_next;
  srdp_pkg::status_t                 error_code, error_code_next;

  logic                              res_valid, res_valid_next;
  logic [srdp_pkg::MANTISSA_BITS-1:0] res_mant, res_mant_next;
  logic [3:0]                        res_frac, res_frac_next;
  srdp_pkg::status_t                 res_stat, res_stat_next;

  logic [srdp_pkg::MAG_BITS-1:0]     acc_add;
  logic                              acc_ovf;
  logic [srdp_pkg::MANTISSA_BITS-1:0] signed_mag;
  srdp_pkg::status_t                 end_stat;

  assign cc = srdp_pkg::classify(item.ch);

  // a carriage return needs the result register free
  assign adv = item.valid && (!cc.is_cr || !res_valid || m_tready);

  srdp_acc u_acc (
    .acc      (acc),
    .digit    (cc.digit),
    .acc_next (acc_add),
    .ovf      (acc_ovf)
  );

  // magnitude with the sign applied
  assign signed_mag = negative ? (~{1'b0, acc} + 1'b1) : {1'b0, acc};

  // status at end of message
  always_comb begin
    if (phase != srdp_pkg::PH_INT && phase != srdp_pkg::PH_FRAC) begin
      end_stat = srdp_pkg::ST_NO_SIGN;
    end else if (error_code != srdp_pkg::ST_OK) begin
      end_stat = error_code;
    end else if (phase == srdp_pkg::PH_INT) begin
      end_stat = srdp_pkg::ST_NO_POINT;
    end else begin
      end_stat = srdp_pkg::ST_OK;
    end
  end

  // next state and result
  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    acc_next         = acc;
    digit_count_next = digit_count;
    error_code_next  = error_code;
    res_mant_next    = res_mant;
    res_frac_next    = res_frac;
    res_stat_next    = res_stat;
    res_valid_next   = res_valid && !m_tready;

    if (adv) begin
      if (cc.is_cr) begin
        // end of message: load result and restart
        res_valid_next = 1'b1;
        res_stat_next  = end_stat;
        if (end_stat == srdp_pkg::ST_OK || end_stat == srdp_pkg::ST_OVERFLOW) begin
          res_mant_next = signed_mag;
          res_frac_next = digit_count;
        end else begin
          res_mant_next = '0;
          res_frac_next = '0;
        end
        phase_next       = srdp_pkg::PH_SEEK;
        negative_next    = 1'b0;
        acc_next         = '0;
        digit_count_next = '0;
        error_code_next  = srdp_pkg::ST_OK;
      end else begin
        unique case (phase)
          srdp_pkg::PH_INT, srdp_pkg::PH_FRAC: begin
            if (cc.is_digit) begin
              // extra fraction digits are dropped
              if (phase == srdp_pkg::PH_INT ||
                  digit_count < 4'(srdp_pkg::MAX_FRACTION_DIGITS)) begin
                acc_next = acc_add;
                if (acc_ovf && error_code == srdp_pkg::ST_OK) begin
                  error_code_next = srdp_pkg::ST_OVERFLOW;
                end
                if (phase == srdp_pkg::PH_FRAC) begin
                  digit_count_next = digit_count + 4'd1;
                end
              end
            end else if (cc.is_point && phase == srdp_pkg::PH_INT) begin
              phase_next = srdp_pkg::PH_FRAC;
            end else if (error_code == srdp_pkg::ST_OK) begin
              error_code_next = srdp_pkg::ST_NON_DIGIT;
            end
          end
          default: begin
            // seeking the sign, all else is skipped
            if (cc.is_plus || cc.is_minus) begin
              negative_next    = cc.is_minus;
              phase_next       = srdp_pkg::PH_INT;
              acc_next         = '0;
              digit_count_next = '0;
              error_code_next  = srdp_pkg::ST_OK;
            end
          end
        endcase
      end
    end
  end

  // control and parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= srdp_pkg::PH_SEEK;
      negative    <= 1'b0;
      acc         <= '0;
      digit_count <= '0;
      error_code  <= srdp_pkg::ST_OK;
      res_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      negative    <= negative_next;
      acc         <= acc_next;
      digit_count <= digit_count_next;
      error_code  <= error_code_next;
      res_valid   <= res_valid_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    res_mant <= res_mant_next;
    res_frac <= res_frac_next;
    res_stat <= res_stat_next;
  end

  assign m_tvalid    = res_valid;
  assign mantissa    = res_mant;
  assign frac_digits = res_frac;
  assign status      = res_stat;

endmodule

FILE: design/scale_reading_decimal_parser.sv
// ----------------------------------------------------------------------------
// scale_reading_decimal_parser
// ASCII signed decimal reading to mantissa and decimal exponent
// ----------------------------------------------------------------------------
// Characters enter on the s_ channel, one per transfer. Text before the first
// sign is skipped; after it, integer digits, an optional point and fraction
// digits are gathered. A carriage return ends the message and yields one
// transfer on the m_ channel: value = mantissa x 10^-frac_digits, with the
// status code in m_tuser. All other characters yield no output.
// Path: a carriage return passes two registers, the input register and then
// the result register, before its result shows on m_tvalid.
// Throughput: one character per cycle save for stalls, set by the single
// saturating multiply-by-ten-and-add on the magnitude between both registers.
// When the receiver stalls, the result is held; characters other than the
// carriage return keep being accepted, and a following carriage return waits
// in the input register until the result has been taken.
// Reset empties both registers and returns the parser to seeking the sign.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scale_reading_decimal_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [47:0] mantissa, [51:48] frac_digits, zero pad
  output logic [2:0]  m_tuser    // [2:0] status
);

  srdp_pkg::in_item_t                 item;
  logic                               adv;
  logic [srdp_pkg::MANTISSA_BITS-1:0] mantissa;
  logic [3:0]                         frac_digits;
  logic [2:0]                         status;
  logic                               take_cr;

  srdp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .adv      (adv),
    .item     (item)
  );

  srdp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .adv         (adv),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .mantissa    (mantissa),
    .frac_digits (frac_digits),
    .status      (status)
  );

  // pack result fields
  assign m_tdata = {4'b0000, frac_digits, mantissa};
  assign m_tuser = status;

  assign take_cr = adv && (item.ch == srdp_pkg::CH_CR);

  // checks
  `ASSERT_NEXT(a_cr_gives_result, clk, rst, take_cr, m_tvalid)
  `ASSERT_IMPL(a_error_fields_zero, clk, rst,
    m_tvalid && (m_tuser == srdp_pkg::ST_NO_SIGN || m_tuser == srdp_pkg::ST_NO_POINT ||
    m_tuser == srdp_pkg::ST_NON_DIGIT), m_tdata == '0)
  `ASSERT_IMPL(a_status_range, clk, rst, m_tvalid, m_tuser <= srdp_pkg::ST_OVERFLOW)
  `ASSERT_NEXT(a_cr_waits, clk, rst,
    item.valid && (item.ch == srdp_pkg::CH_CR) && m_tvalid && !m_tready,
    item.valid && (item.ch == srdp_pkg::CH_CR))

endmodule

FILE: sim/srdp_checker.sv
// ----------------------------------------------------------------------------
// srdp_checker
// Watches both channels of the parser, predicts each reading and compares it
// ----------------------------------------------------------------------------
// Every character transfer on the s_ channel steps a private copy of the
// parser state. A carriage return queues the reading it should produce.
// Every transfer on the m_ channel is matched against the oldest queued
// reading, field by field, including the zero pad at the top of m_tdata.
// ----------------------------------------------------------------------------
module srdp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,   // [47:0] mantissa, [51:48] frac_digits, zero pad
  input  logic [2:0]  m_tuser,   // [2:0] status
  output int          mismatches,
  output int          outstanding,
  output int          readings,
  output int          flagged
);

  localparam logic [63:0] MAG_LIMIT = (64'd1 << srdp_pkg::MAG_BITS) - 64'd1;

  // one reading as it leaves the parser
  typedef struct packed {
    logic [3:0]        pad;
    srdp_pkg::status_t status;
    logic [3:0]        frac_digits;
    logic [47:0]       mantissa;
  } reading_t;

  reading_t          pending_readings[$];

  // shadow parser state
  srdp_pkg::phase_t  phase;
  logic              negative;
  logic [63:0]       magnitude;
  logic [3:0]        frac_count;
  srdp_pkg::status_t error_code;

  task automatic clear_parse();
    phase      = srdp_pkg::PH_SEEK;
    negative   = 1'b0;
    magnitude  = '0;
    frac_count = '0;
    error_code = srdp_pkg::ST_OK;
  endtask

  // saturating multiply by ten and add, first error wins
  task automatic push_digit(input logic [3:0] d);
    if (magnitude > (MAG_LIMIT - 64'(d)) / 64'd10) begin
      magnitude = MAG_LIMIT;
      if (error_code == srdp_pkg::ST_OK) error_code = srdp_pkg::ST_OVERFLOW;
    end else begin
      magnitude = magnitude * 64'd10 + 64'(d);
    end
  endtask

  // step the shadow parser by one character
  task automatic track_char(input logic [7:0] c);
    reading_t r;
    logic     in_number;
    logic     is_digit;
    in_number = (phase == srdp_pkg::PH_INT) || (phase == srdp_pkg::PH_FRAC);
    is_digit  = (c >= srdp_pkg::CH_ZERO) && (c <= srdp_pkg::CH_NINE);
    if (c == srdp_pkg::CH_CR) begin
      r = '0;
      if (!in_number)                          r.status = srdp_pkg::ST_NO_SIGN;
      else if (error_code != srdp_pkg::ST_OK)  r.status = error_code;
      else if (phase == srdp_pkg::PH_INT)      r.status = srdp_pkg::ST_NO_POINT;
      else                                     r.status = srdp_pkg::ST_OK;
      if (r.status == srdp_pkg::ST_OK || r.status == srdp_pkg::ST_OVERFLOW) begin
        r.mantissa    = negative ? 48'd0 - magnitude[47:0] : magnitude[47:0];
        r.frac_digits = frac_count;
      end
      pending_readings.push_back(r);
      clear_parse();
    end else if (in_number) begin
      if (is_digit) begin
        if (phase == srdp_pkg::PH_INT) begin
          push_digit(4'(c - srdp_pkg::CH_ZERO));
        end else if (frac_count < srdp_pkg::MAX_FRACTION_DIGITS) begin
          push_digit(4'(c - srdp_pkg::CH_ZERO));
          frac_count = frac_count + 4'd1;
        end
      end else if (c == srdp_pkg::CH_POINT && phase == srdp_pkg::PH_INT) begin
        phase = srdp_pkg::PH_FRAC;
      end else if (error_code == srdp_pkg::ST_OK) begin
        error_code = srdp_pkg::ST_NON_DIGIT;
      end
    end else if (c == srdp_pkg::CH_PLUS || c == srdp_pkg::CH_MINUS) begin
      negative   = (c == srdp_pkg::CH_MINUS);
      phase      = srdp_pkg::PH_INT;
      magnitude  = '0;
      frac_count = '0;
      error_code = srdp_pkg::ST_OK;
    end
  endtask

  task automatic flag(input string what, input reading_t want, input reading_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s) at %0t: expected mantissa %0d frac %0d status %0d pad %0d,",
               what, $realtime, $signed(want.mantissa), want.frac_digits, want.status,
               want.pad);
    if (mismatches <= 10)
      $display("  got mantissa %0d frac %0d status %0d pad %0d",
               $signed(got.mantissa), got.frac_digits, got.status, got.pad);
  endtask

  // compare output transfers, then step on input transfers
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (rst) begin
      clear_parse();
      pending_readings.delete();
      mismatches  <= 0;
      outstanding <= 0;
      readings    <= 0;
      flagged     <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[55:52], srdp_pkg::status_t'(m_tuser), m_tdata[51:48],
               m_tdata[47:0]};
        if (pending_readings.size() == 0) begin
          flag("no reading pending", '0, got);
        end else begin
          want = pending_readings.pop_front();
          readings++;
          if (want.status != srdp_pkg::ST_OK) flagged++;
          if (got !== want) flag("wrong field", want, got);
        end
      end
      if (s_tvalid && s_tready) track_char(s_tdata);
      outstanding <= pending_readings.size();
    end
  end

endmodule

FILE: sim/scale_reading_decimal_parser_tb.sv
// ----------------------------------------------------------------------------
// scale_reading_decimal_parser_tb
// Stimulus and verdict for the scale reading decimal parser
// ----------------------------------------------------------------------------
// A directed set of readings covers skipped text, missing sign, missing
// point, stray characters, overflow, dropped fraction digits and empty parts.
// Random readings follow, mostly well formed with random lengths and some
// stray characters, plus raw byte noise, over four idle and stall phases.
// srdp_checker predicts and compares; this module only drives and judges.
// ----------------------------------------------------------------------------
module scale_reading_decimal_parser_tb;

  localparam int STALL_LIMIT = 5000;
  localparam int CHARS_PER_PHASE = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [2:0]  m_tuser;

  int mismatches;
  int outstanding;
  int readings;
  int flagged;
  int chars_sent = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int quiet_cycles = 0;

  scale_reading_decimal_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  srdp_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .readings    (readings),
    .flagged     (flagged)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one character transfer, with random sender gaps before it
  task automatic put_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
  endtask

  // text followed by a carriage return
  task automatic send_line(input string body);
    for (int i = 0; i < body.len(); i++) put_char(body[i]);
    put_char(srdp_pkg::CH_CR);
  endtask

  function automatic logic [7:0] stray_char();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0: c = srdp_pkg::CH_POINT;
      1: c = srdp_pkg::CH_PLUS;
      2: c = srdp_pkg::CH_MINUS;
      3: c = 8'hFF;
      default: begin
        do c = 8'($urandom_range(0, 255)); while (c == srdp_pkg::CH_CR);
      end
    endcase
    return c;
  endfunction

  // one random reading: mostly well formed, some noise or no sign
  task automatic send_reading();
    int         kind;
    int         n_int;
    int         n_frac;
    int         bad_at;
    bit         with_point;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // raw byte noise, any value
      repeat ($urandom_range(1, 8)) put_char(8'($urandom_range(0, 255)));
      put_char(srdp_pkg::CH_CR);
    end else begin
      // leading text that holds no sign
      repeat ($urandom_range(0, 3)) begin
        do c = 8'($urandom_range(0, 255));
        while (c == srdp_pkg::CH_PLUS || c == srdp_pkg::CH_MINUS || c == srdp_pkg::CH_CR);
        put_char(c);
      end
      if (kind < 15) begin
        put_char(srdp_pkg::CH_CR);
      end else begin
        put_char($urandom_range(0, 1) ? srdp_pkg::CH_MINUS : srdp_pkg::CH_PLUS);
        n_int = ($urandom_range(0, 99) < 12) ? $urandom_range(14, 19) : $urandom_range(0, 4);
        with_point = ($urandom_range(0, 99) < 85);
        n_frac = !with_point ? 0 :
                 ($urandom_range(0, 99) < 12) ? $urandom_range(13, 18) : $urandom_range(0, 4);
        bad_at = ($urandom_range(0, 99) < 12) ? $urandom_range(0, n_int + n_frac) : -1;
        for (int i = 0; i <= n_int + n_frac; i++) begin
          if (i == bad_at) put_char(stray_char());
          if (i == n_int && with_point) put_char(srdp_pkg::CH_POINT);
          if (i < n_int + n_frac) put_char(srdp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        put_char(srdp_pkg::CH_CR);
      end
    end
  endtask

  initial begin
    int target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed readings
    send_line("");
    put_char(8'h00);
    put_char(8'hFF);
    send_line("7.");
    send_line("+.");
    send_line("-0");
    send_line("-12.50");
    send_line("+3.1.4");
    send_line("-2+");
    put_char(srdp_pkg::CH_PLUS);
    put_char(8'hFF);
    put_char(srdp_pkg::CH_CR);
    send_line("+140737488355327.");
    send_line("S,-9999999999999999.5");
    send_line("-.1234567890123456789");

    // random readings over four idling phases
    target = chars_sent;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 82; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 82; end
        default: begin src_idle_pct = 24; sink_stall_pct = 24; end
      endcase
      target += CHARS_PER_PHASE;
      while (chars_sent < target) send_reading();
    end
    s_tvalid <= 1'b0;

    // drain, once the last transfer has reached the pending count
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d characters over four idle/stall phases", chars_sent);
    $display("compared %0d readings, %0d of them with an error status", readings, flagged);
    if (outstanding != 0) $display("readings never returned: %0d", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/srdp_pkg.sv
design/srdp_in_stage.sv
design/srdp_acc.sv
design/srdp_parser.sv
design/scale_reading_decimal_parser.sv
sim/srdp_checker.sv
sim/scale_reading_decimal_parser_tb.sv
